[sv/amgw_pkg.sv]
// Shared types and constants for the adjacency matrix graph walker.
// Used by the controller, the datapath, the top level and the checker.
package amgw_pkg;

  localparam int NV        = 16;               // vertex table depth
  localparam int KEY_W     = 16;               // key width
  localparam int IDX_W     = $clog2(NV);       // vertex index width
  localparam int CNT_W     = $clog2(NV + 1);   // vertex count width
  localparam int PEND_D    = NV * NV + 1;      // pending list depth
  localparam int PEND_AW   = $clog2(PEND_D + 1);
  localparam int CAP_W     = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [2:0] {
    FN_ADD_V   = 3'd0,
    FN_DEL_V   = 3'd1,
    FN_ADD_E   = 3'd2,
    FN_DEL_E   = 3'd3,
    FN_QUERY   = 3'd4,
    FN_NBRS    = 3'd5,
    FN_DFS     = 3'd6,
    FN_BFS     = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_DIRECTED = 1'b0,
    REG_CAPACITY = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LK_A = 2'd0,
    LK_B = 2'd1,
    LK_J = 2'd2
  } lk_sel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK_A, S_LOOK_B, S_EXEC, S_NB_SCAN,
    S_W_POP, S_W_CHECK, S_W_SCAN, S_FLUSH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    ld_in;
    lk_sel_t lk_sel;
    logic    cap_a;
    logic    cap_b;
    logic    do_add;
    logic    do_remove;
    logic    do_edge;
    logic    kaddr_pq;
    logic    emit;
    status_t em_status;
    logic    em_key;
    logic    em_ans;
    logic    flush;
    logic    j_clr;
    logic    j_inc;
    logic    w_init;
    logic    pop;
    logic    visit;
    logic    push;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_t func;
    logic  fa;
    logic  fb;
    logic  full;
    logic  j_done;
    logic  row_bit;
    logic  pend_empty;
    logic  seen;
    logic  hold_v;
    logic  out_free;
  } stat_t;

endpackage

[sv/adjacency_matrix_graph_walker_top.sv]
// Channel   Dir  Handshake          Payload
// in_       in   tvalid/tready      tdata: func, key_a, key_b
// out_      out  tvalid/tready      tdata: status, key_out, has_key, answer; tlast
// cfg_      in   we                 addr: register index, wdata: value
//
// One operation at a time. Vertex and edge edits and edge queries go through input
// latch, two lookups through the shared compare unit, execute and flush.
// A neighbour list adds a step per live vertex plus the end check;
// a walk adds a pop and a check per pending-list pop, a scan step per live vertex
// for each visited vertex and one final empty check.
// Synchronous active-low reset clears the graph, no clearing pass is needed.
// A stalled output holds the sequencer when a second result is ready, and at the final flush.
// Top level of the graph walker; uses amgw_pkg, amgw_ctrl and amgw_dp.
module adjacency_matrix_graph_walker_top import amgw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // func[2:0], key_a[18:3], key_b[34:19]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // status[1:0], key_out[17:2], has_key[18],
                                            // answer[19]
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_addr,
  input  logic [CAP_W-1:0]      cfg_wdata
);

  cmd_t             cmd;
  stat_t            st;
  logic [1:0]       o_status;
  logic [KEY_W-1:0] o_key;
  logic             o_has, o_ans;

  amgw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  amgw_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_func     (in_tdata[2:0]),
    .in_key_a    (in_tdata[18:3]),
    .in_key_b    (in_tdata[34:19]),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (o_status),
    .out_key     (o_key),
    .out_has_key (o_has),
    .out_answer  (o_ans),
    .out_last    (out_tlast)
  );

  assign out_tdata = {4'b0, o_ans, o_has, o_key, o_status};

endmodule

[sv/amgw_ctrl.sv]
// Sequencer for the graph walker: decodes one operation and steps the datapath.
// Depends on amgw_pkg.
module amgw_ctrl import amgw_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   emit_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // room for a new result: holding slot empty or output can take it
  assign emit_ok = !st.hold_v || st.out_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_LOOK_A;
        end
      end
      S_LOOK_A: begin
        cmd.lk_sel = LK_A;
        cmd.cap_a  = 1'b1;
        state_nxt  = S_LOOK_B;
      end
      S_LOOK_B: begin
        cmd.lk_sel = LK_B;
        cmd.cap_b  = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_FLUSH;
        if (st.func == FN_ADD_V) begin
          cmd.emit = 1'b1;
          if (st.full) begin
            cmd.em_status = ST_FULL;
          end else begin
            cmd.do_add    = 1'b1;
            cmd.em_status = ST_OK;
          end
        end else if (!st.fa || (!st.fb && (st.func == FN_ADD_E ||
                     st.func == FN_DEL_E || st.func == FN_QUERY))) begin
          cmd.emit      = 1'b1;
          cmd.em_status = ST_NOT_FOUND;
        end else begin
          case (st.func)
            FN_DEL_V: begin
              cmd.do_remove = 1'b1;
              cmd.emit      = 1'b1;
            end
            FN_ADD_E, FN_DEL_E: begin
              cmd.do_edge = 1'b1;
              cmd.emit    = 1'b1;
            end
            FN_QUERY: begin
              cmd.emit   = 1'b1;
              cmd.em_ans = 1'b1;
            end
            FN_NBRS: begin
              cmd.j_clr = 1'b1;
              state_nxt = S_NB_SCAN;
            end
            FN_DFS, FN_BFS: begin
              cmd.w_init = 1'b1;
              state_nxt  = S_W_POP;
            end
            default: state_nxt = S_FLUSH;
          endcase
        end
      end
      // neighbour list: one column per cycle, unless a found neighbour waits on a stalled output
      S_NB_SCAN: begin
        if (st.j_done) begin
          if (!st.hold_v) cmd.emit = 1'b1;   // empty list still gives one beat
          state_nxt = S_FLUSH;
        end else if (st.row_bit) begin
          if (emit_ok) begin
            cmd.emit   = 1'b1;
            cmd.em_key = 1'b1;
            cmd.j_inc  = 1'b1;
          end
        end else begin
          cmd.j_inc = 1'b1;
        end
      end
      // walk: pop, check, scan row
      S_W_POP: begin
        if (st.pend_empty) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_W_CHECK;
        end
      end
      S_W_CHECK: begin
        cmd.kaddr_pq = 1'b1;
        if (st.seen) begin
          state_nxt = S_W_POP;
        end else if (emit_ok) begin
          cmd.visit  = 1'b1;
          cmd.emit   = 1'b1;
          cmd.em_key = 1'b1;
          cmd.j_clr  = 1'b1;
          state_nxt  = S_W_SCAN;
        end
      end
      S_W_SCAN: begin
        cmd.lk_sel = LK_J;
        if (st.j_done) begin
          state_nxt = S_W_POP;
        end else begin
          cmd.push  = st.row_bit;
          cmd.j_inc = 1'b1;
        end
      end
      S_FLUSH: begin
        if (st.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[sv/amgw_dp.sv]
// Datapath of the graph walker: key table, adjacency rows, pending list,
// lookup unit, result holding slot and output register. Depends on amgw_pkg.
module amgw_dp import amgw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 st,
  input  logic [2:0]            in_func,
  input  logic [KEY_W-1:0]      in_key_a,
  input  logic [KEY_W-1:0]      in_key_b,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_addr,
  input  logic [CAP_W-1:0]      cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [KEY_W-1:0]      out_key,
  output logic                  out_has_key,
  output logic                  out_answer,
  output logic                  out_last
);

  // configuration
  logic             directed_r;
  logic [CAP_W-1:0] cap_r;

  // operation registers
  func_t            func_r;
  logic [KEY_W-1:0] ka_r, kb_r;
  logic [IDX_W-1:0] ia_r, ib_r, cur_r;
  logic             fa_r, fb_r;
  logic [CNT_W-1:0] j_r;

  // graph state
  logic [KEY_W-1:0] keys_r [NV];
  logic [NV-1:0]    rows_r [NV];
  logic [CNT_W-1:0] count_r;
  logic [NV-1:0]    visited_r;

  // pending list
  logic [IDX_W-1:0]   pend_mem [PEND_D];
  logic [PEND_AW-1:0] head_r, tail_r, rd_addr;
  logic [IDX_W-1:0]   pend_q_r;

  // result slot and output register
  logic             hold_v_r;
  status_t          hold_status_r;
  logic [KEY_W-1:0] hold_key_r;
  logic             hold_has_r, hold_ans_r;
  logic             out_v_r;
  logic [1:0]       out_status_r;
  logic [KEY_W-1:0] out_key_r;
  logic             out_has_r, out_ans_r, out_last_r;

  // shared signals
  logic [IDX_W-1:0] key_addr, lk_idx;
  logic [KEY_W-1:0] key_rd, lk_key;
  logic             lk_hit;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] cnt_m1;
  logic [NV-1:0]    lo_mask, keep_mask;
  logic             out_free;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      directed_r <= 1'b0;
      cap_r      <= CAP_W'(NV);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_DIRECTED: directed_r <= cfg_wdata[0];
        REG_CAPACITY: cap_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // single key read port
  assign key_addr = cmd.kaddr_pq ? pend_q_r : j_r[IDX_W-1:0];
  assign key_rd   = keys_r[key_addr];

  // first-match lookup over the live entries
  always_comb begin
    case (cmd.lk_sel)
      LK_A:    lk_key = ka_r;
      LK_B:    lk_key = kb_r;
      default: lk_key = key_rd;
    endcase
    lk_hit = 1'b0;
    lk_idx = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (CNT_W'(i) < count_r && keys_r[i] == lk_key) begin
        lk_hit = 1'b1;
        lk_idx = IDX_W'(i);
      end
    end
  end

  assign limit     = (CNT_W'(cap_r) < CNT_W'(NV)) ? CNT_W'(cap_r) : CNT_W'(NV);
  assign cnt_m1    = count_r - 1'b1;
  assign lo_mask   = ~({NV{1'b1}} << ia_r);
  assign keep_mask = ~({NV{1'b1}} << cnt_m1[IDX_W-1:0]);
  assign out_free  = !out_v_r || out_ready;

  // input, lookup results and scan index
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      func_r <= func_t'(in_func);
      ka_r   <= in_key_a;
      kb_r   <= in_key_b;
    end
    if (cmd.cap_a) begin
      ia_r <= lk_idx;
      fa_r <= lk_hit;
    end
    if (cmd.cap_b) begin
      ib_r  <= lk_idx;
      fb_r  <= lk_hit;
      cur_r <= ia_r;
    end
    if (cmd.visit) cur_r <= pend_q_r;
    if (cmd.j_clr)      j_r <= '0;
    else if (cmd.j_inc) j_r <= j_r + 1'b1;
  end

  // key table and adjacency rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < NV; i++) rows_r[i] <= '0;
    end else if (cmd.do_add) begin
      keys_r[count_r[IDX_W-1:0]] <= ka_r;
      rows_r[count_r[IDX_W-1:0]] <= '0;
      count_r <= count_r + 1'b1;
    end else if (cmd.do_remove) begin
      // shift entries above ia down, drop column ia, clear freed row
      for (int i = 0; i < NV; i++) begin
        logic [NV-1:0] src;
        src = rows_r[i];
        if (i < NV - 1 && IDX_W'(i) >= ia_r) begin
          src        = rows_r[(i + 1) % NV];
          keys_r[i] <= keys_r[(i + 1) % NV];
        end
        if (CNT_W'(i) >= cnt_m1) rows_r[i] <= '0;
        else rows_r[i] <= ((src & lo_mask) | ((src >> 1) & ~lo_mask)) & keep_mask;
      end
      count_r <= cnt_m1;
    end else if (cmd.do_edge) begin
      rows_r[ia_r][ib_r] <= (func_r == FN_ADD_E);
      if (!directed_r) rows_r[ib_r][ia_r] <= (func_r == FN_ADD_E);
    end
  end

  // pending list and visit marks
  assign rd_addr = (func_r == FN_DFS) ? tail_r - 1'b1 : head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      visited_r <= '0;
    end else begin
      if (cmd.w_init) begin
        head_r    <= '0;
        tail_r    <= PEND_AW'(1);
        visited_r <= '0;
      end else if (cmd.pop) begin
        if (func_r == FN_DFS) tail_r <= tail_r - 1'b1;
        else                  head_r <= head_r + 1'b1;
      end else if (cmd.push) begin
        tail_r <= tail_r + 1'b1;
      end
      if (cmd.visit) visited_r[pend_q_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.w_init)    pend_mem[0] <= ia_r;
    else if (cmd.push) pend_mem[tail_r] <= lk_idx;
    if (cmd.pop)       pend_q_r <= pend_mem[rd_addr];
  end

  // result slot: previous result moves out when a newer one arrives or on flush
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.flush) begin
        out_v_r      <= 1'b1;
        out_status_r <= hold_status_r;
        out_key_r    <= hold_key_r;
        out_has_r    <= hold_has_r;
        out_ans_r    <= hold_ans_r;
        out_last_r   <= 1'b1;
        hold_v_r     <= 1'b0;
      end else if (cmd.emit && hold_v_r) begin
        out_v_r      <= 1'b1;
        out_status_r <= hold_status_r;
        out_key_r    <= hold_key_r;
        out_has_r    <= hold_has_r;
        out_ans_r    <= hold_ans_r;
        out_last_r   <= 1'b0;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (cmd.emit) begin
        hold_v_r      <= 1'b1;
        hold_status_r <= cmd.em_status;
        hold_key_r    <= cmd.em_key ? key_rd : '0;
        hold_has_r    <= cmd.em_key;
        hold_ans_r    <= cmd.em_ans ? rows_r[cur_r][ib_r] : 1'b0;
      end
    end
  end

  // status to controller
  assign st.func       = func_r;
  assign st.fa         = fa_r;
  assign st.fb         = fb_r;
  assign st.full       = count_r >= limit;
  assign st.j_done     = j_r >= count_r;
  assign st.row_bit    = rows_r[cur_r][j_r[IDX_W-1:0]];
  assign st.pend_empty = head_r == tail_r;
  assign st.seen       = visited_r[pend_q_r];
  assign st.hold_v     = hold_v_r;
  assign st.out_free   = out_free;

  assign out_valid   = out_v_r;
  assign out_status  = out_status_r;
  assign out_key     = out_key_r;
  assign out_has_key = out_has_r;
  assign out_answer  = out_ans_r;
  assign out_last    = out_last_r;

endmodule

[sv/amgw_chk.sv]
// Port-level checker for the graph walker, bound to the top level.
// Depends on amgw_pkg.
module amgw_chk import amgw_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // an error is a single beat without a key
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tlast && !out_tdata[18])
    else $error("error result not a lone beat");

  // a query answer never comes with a key
  a_ans_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] |-> out_tlast && !out_tdata[18])
    else $error("edge answer on a keyed or non-final beat");

endmodule

bind adjacency_matrix_graph_walker_top amgw_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[tb/tb_adjacency_matrix_graph_walker_top.sv]
// Self-checking testbench for the adjacency matrix graph walker.
// Drives operation beats, predicts every result beat in a local graph model
// and compares them in order. Depends on amgw_pkg and the top level only.
module tb_adjacency_matrix_graph_walker_top;
  import amgw_pkg::*;

  typedef struct packed {
    func_t       func;
    logic [15:0] key_a;
    logic [15:0] key_b;
  } op_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] key_out;
    logic        has_key;
    logic        answer;
    logic        last;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_addr = '0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  adjacency_matrix_graph_walker_top dut (.*);

  always #4 clk = ~clk;

  // graph model state
  logic [15:0] g_keys [NV];
  int          g_count;
  logic [15:0] g_rows [NV];
  logic        g_directed;
  int          g_cap;

  op_t  op_queue [$];
  res_t expected_beats [$];
  int   errors = 0;
  int   ops_sent = 0;
  int   beats_seen = 0;
  int   walk_beats = 0;
  bit   idle_off = 1'b0;
  bit   long_hold_go = 1'b0;
  bit   long_hold_done = 1'b0;
  logic [15:0] key_pool [8];

  function automatic int lookup(logic [15:0] k);
    for (int i = 0; i < g_count; i++)
      if (g_keys[i] == k) return i;
    return -1;
  endfunction

  function automatic void add_result(ref res_t beats[$], input status_t st,
                                     input logic [15:0] k, input logic h, input logic a);
    res_t r;
    if (beats.size() >= 16) return;
    r.status = st; r.key_out = k; r.has_key = h; r.answer = a; r.last = 1'b0;
    beats = {beats, r};
  endfunction

  // Apply one operation to the model and queue its result beats.
  function automatic void model_op(op_t op);
    res_t beats [$];
    int ia, ib, n, cur, head, tail;
    int pend [PEND_D];
    logic [15:0] seen;
    ia = lookup(op.key_a);
    ib = lookup(op.key_b);
    if (op.func == FN_ADD_V) begin
      if (g_count >= ((g_cap < NV) ? g_cap : NV)) begin
        add_result(beats, ST_FULL, 16'h0, 1'b0, 1'b0);
      end else begin
        g_keys[g_count] = op.key_a;
        g_rows[g_count] = '0;
        g_count++;
        add_result(beats, ST_OK, 16'h0, 1'b0, 1'b0);
      end
    end else if (ia < 0 || (op.func inside {FN_ADD_E, FN_DEL_E, FN_QUERY} && ib < 0)) begin
      add_result(beats, ST_NOT_FOUND, 16'h0, 1'b0, 1'b0);
    end else begin
      case (op.func)
        FN_DEL_V: begin
          for (int i = ia; i + 1 < g_count; i++) begin
            g_keys[i] = g_keys[i+1];
            g_rows[i] = g_rows[i+1];
          end
          n = g_count - 1;
          g_keys[n] = '0;
          g_rows[n] = '0;
          // squeeze column ia out of every remaining row
          for (int i = 0; i < n; i++) begin
            g_rows[i] = (g_rows[i] & ((16'h1 << ia) - 16'h1)) |
                        ((g_rows[i] >> (ia + 1)) << ia);
            g_rows[i] &= (16'h1 << n) - 16'h1;
          end
          g_count = n;
          add_result(beats, ST_OK, 16'h0, 1'b0, 1'b0);
        end
        FN_ADD_E, FN_DEL_E: begin
          g_rows[ia][ib] = (op.func == FN_ADD_E);
          if (!g_directed) g_rows[ib][ia] = (op.func == FN_ADD_E);
          add_result(beats, ST_OK, 16'h0, 1'b0, 1'b0);
        end
        FN_QUERY: add_result(beats, ST_OK, 16'h0, 1'b0, g_rows[ia][ib]);
        FN_NBRS: begin
          for (int j = 0; j < g_count; j++)
            if (g_rows[ia][j]) add_result(beats, ST_OK, g_keys[j], 1'b1, 1'b0);
          if (beats.size() == 0) add_result(beats, ST_OK, 16'h0, 1'b0, 1'b0);
        end
        default: begin
          // walk: stack for depth-first, queue for breadth-first
          seen = '0; head = 0; tail = 0;
          pend[tail++] = ia;
          while (head < tail) begin
            if (op.func == FN_DFS) cur = pend[--tail];
            else cur = pend[head++];
            if (!seen[cur]) begin
              seen[cur] = 1'b1;
              add_result(beats, ST_OK, g_keys[cur], 1'b1, 1'b0);
              for (int j = 0; j < g_count; j++)
                if (g_rows[cur][j] && tail < PEND_D) pend[tail++] = lookup(g_keys[j]);
            end
          end
          walk_beats += beats.size();
        end
      endcase
    end
    beats[beats.size()-1].last = 1'b1;
    foreach (beats[i]) expected_beats = {expected_beats, beats[i]};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (beat %0d)", what, got, want, beats_seen);
  endtask

  // driver: sends queued operations, random idle bursts
  int in_gap = 0;
  always @(posedge clk) begin
    logic v;
    op_t op;
    v = in_tvalid;
    if (in_tvalid && in_tready) begin
      op.func  = func_t'(in_tdata[2:0]);
      op.key_a = in_tdata[18:3];
      op.key_b = in_tdata[34:19];
      model_op(op);
      ops_sent++;
      v = 1'b0;
    end
    if (!v) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(1, 9) - 1;
      end else if (op_queue.size() > 0 && rst_n) begin
        op = op_queue.pop_front();
        in_tdata <= {5'b0, op.key_b, op.key_a, op.func};
        v = 1'b1;
      end
    end
    in_tvalid <= v;
  end

  // monitor: checks result beats, random and long holds on tready
  int out_gap = 0;
  always @(posedge clk) begin
    res_t want;
    logic r;
    if (out_tvalid && out_tready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", 32'(out_tdata), 32'(0));
      end else begin
        want = expected_beats.pop_front();
        if (out_tdata[1:0] != want.status)
          report_mismatch("status", 32'(out_tdata[1:0]), 32'(want.status));
        if (out_tdata[17:2] != want.key_out)
          report_mismatch("key_out", 32'(out_tdata[17:2]), 32'(want.key_out));
        if (out_tdata[18] != want.has_key)
          report_mismatch("has_key", 32'(out_tdata[18]), 32'(want.has_key));
        if (out_tdata[19] != want.answer)
          report_mismatch("answer", 32'(out_tdata[19]), 32'(want.answer));
        if (out_tlast != want.last)
          report_mismatch("tlast", 32'(out_tlast), 32'(want.last));
      end
    end
    r = 1'b1;
    if (long_hold_go && !long_hold_done) begin
      long_hold_done <= 1'b1;
      out_gap = 400;
    end
    if (out_gap > 0) begin
      out_gap--;
      r = 1'b0;
    end else if (!idle_off && $urandom_range(0, 6) == 0) begin
      out_gap = $urandom_range(1, 9) - 1;
      r = 1'b0;
    end
    out_tready <= r;
  end

  // watchdog on cycles without any accepted beat
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= CAP_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DIRECTED) g_directed = value[0];
    else g_cap = value;
  endtask

  task automatic drain();
    wait (op_queue.size() == 0 && !in_tvalid && expected_beats.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic queue_op(func_t f, logic [15:0] a, logic [15:0] b);
    op_t op;
    op.func = f; op.key_a = a; op.key_b = b;
    op_queue = {op_queue, op};
  endtask

  function automatic logic [15:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 16'hFFFF);
    return key_pool[$urandom_range(0, 7)];
  endfunction

  task automatic queue_random(int count);
    int w;
    func_t f;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(0, 99);
      if (w < 25) f = FN_ADD_V;
      else if (w < 33) f = FN_DEL_V;
      else if (w < 55) f = FN_ADD_E;
      else if (w < 62) f = FN_DEL_E;
      else if (w < 72) f = FN_QUERY;
      else if (w < 80) f = FN_NBRS;
      else if (w < 90) f = FN_DFS;
      else f = FN_BFS;
      queue_op(f, pick_key(), pick_key());
    end
  endtask

  initial begin
    g_count = 0;
    g_directed = 1'b0;
    g_cap = 16;
    foreach (g_rows[i]) begin
      g_rows[i] = '0;
      g_keys[i] = '0;
    end
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) key_pool[i] = $urandom_range(0, 16'hFFFF);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part: extremes, duplicates, misses, empty lists, walks
    write_reg(REG_DIRECTED, 0);
    write_reg(REG_CAPACITY, 16);
    queue_op(FN_NBRS, 16'h1234, 16'h0);      // lookup on empty table
    queue_op(FN_ADD_V, 16'h0000, 16'h0);
    queue_op(FN_ADD_V, 16'hFFFF, 16'hFFFF);
    queue_op(FN_ADD_V, 16'h5A5A, 16'h0);
    queue_op(FN_ADD_V, 16'hFFFF, 16'h0);     // duplicate key
    queue_op(FN_ADD_V, 16'hA5A5, 16'h0);
    queue_op(FN_NBRS, 16'h0000, 16'h0);      // no neighbours
    queue_op(FN_ADD_E, 16'h0000, 16'hFFFF);
    queue_op(FN_ADD_E, 16'hFFFF, 16'h5A5A);
    queue_op(FN_ADD_E, 16'h5A5A, 16'hA5A5);
    queue_op(FN_ADD_E, 16'h0000, 16'hA5A5);
    queue_op(FN_ADD_E, 16'h0000, 16'h7777);  // missing destination
    queue_op(FN_QUERY, 16'hA5A5, 16'h5A5A);
    queue_op(FN_QUERY, 16'h5A5A, 16'h0000);
    queue_op(FN_NBRS, 16'h0000, 16'h0);
    queue_op(FN_DFS, 16'h0000, 16'h0);
    queue_op(FN_BFS, 16'h0000, 16'h0);
    queue_op(FN_DEL_E, 16'h0000, 16'hA5A5);
    queue_op(FN_DEL_V, 16'hFFFF, 16'h0);     // removes the first copy
    queue_op(FN_DFS, 16'hA5A5, 16'h0);
    queue_op(FN_DEL_V, 16'h7777, 16'h0);     // missing vertex
    queue_op(FN_BFS, 16'h5A5A, 16'h0);
    drain();

    // one-way edges, capacity already exceeded: adds report full
    write_reg(REG_DIRECTED, 1);
    write_reg(REG_CAPACITY, 1);
    queue_op(FN_ADD_V, 16'h1111, 16'h0);
    queue_op(FN_ADD_E, 16'hA5A5, 16'h0000);
    queue_op(FN_QUERY, 16'h0000, 16'hA5A5);
    queue_op(FN_DFS, 16'hA5A5, 16'h0);
    queue_random(30);
    drain();

    // random phases across settings; the second one holds the output off
    write_reg(REG_CAPACITY, 16);
    queue_random(60);
    drain();
    write_reg(REG_DIRECTED, 0);
    write_reg(REG_CAPACITY, 5);
    long_hold_go = 1'b1;
    queue_random(60);
    drain();
    write_reg(REG_CAPACITY, 16);
    idle_off = 1'b1;
    queue_random(80);
    drain();

    $display("Covered %0d operations, %0d result beats (%0d from walks), both edge modes",
             ops_sent, beats_seen, walk_beats);
    $display("and capacity settings 1, 5 and 16 with long and random output holds.");
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
